>>> rtl/core/imhq_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed max-heap queue: default sizes, field widths,
// action and status codes and the sequencer state type. No dependencies.
package imhq_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int KEY_BITS_DEF  = 32;

    localparam int ACT_W       = 3;
    localparam int NODE_W      = 10;
    localparam int IN_KEY_W    = 32;
    localparam int COUNT_OUT_W = 11;
    localparam int STAT_W      = 2;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 72;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_POP    = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_ABSENT  = 2'd2,
        STAT_PRESENT = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_LAST_RD,
        S_LAST_WAIT,
        S_CUR_RD,
        S_CUR_WAIT,
        S_UP_RD,
        S_UP_WAIT,
        S_DN_RD,
        S_DN_WL,
        S_DN_WR,
        S_DN_MV,
        S_CLR_RD,
        S_CLR_WR,
        S_TOP_RD,
        S_TOP_WAIT
    } t_state;

endpackage

>>> rtl/core/imhq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/indexed_max_heap_queue.sv
`timescale 1ns / 1ps
// Indexed max-heap queue top level; uses imhq_pkg and two imhq_ram instances.
// One item at a time. A sift-down step reads the two children one after another
// on the single heap read port, and clear reads every entry to mark its node absent.
// After reset a clearing pass over min(MAX_NODES, 1024) position entries marks
// every node absent before the first item is taken. The result register frees
// the input.
module indexed_max_heap_queue #(
    parameter int MAX_NODES = imhq_pkg::MAX_NODES_DEF,
    parameter int KEY_BITS  = imhq_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // action[2:0], node_id[12:3], key[44:13], zero pad
    input  logic [imhq_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // popped_node[9:0], popped_valid[10], top_node[20:11], top_key[52:21],
    // entry_count_out[63:53], status[65:64], zero pad
    output logic [imhq_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int NW  = imhq_pkg::NODE_W;
    localparam int KW  = (KEY_BITS < imhq_pkg::IN_KEY_W) ? KEY_BITS : imhq_pkg::IN_KEY_W;
    localparam int AW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int PD  = (MAX_NODES < (1 << NW)) ? MAX_NODES : (1 << NW);
    localparam int PAW = $clog2(PD);
    localparam int HW  = KW + NW;
    localparam int PW  = AW + 1;

    imhq_pkg::t_state  r_state, n_state;
    imhq_pkg::t_action r_act, n_act;
    imhq_pkg::t_status r_status, n_status;
    logic [NW-1:0]  r_node, n_node;
    logic [KW-1:0]  r_key, n_key;
    logic [KW-1:0]  r_mk, n_mk;
    logic [NW-1:0]  r_mn, n_mn;
    logic [KW-1:0]  r_ck, n_ck;
    logic [NW-1:0]  r_cn, n_cn;
    logic [AW-1:0]  r_c, n_c;
    logic [AW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_ci, n_ci;
    logic [PAW-1:0] r_init, n_init;
    logic [NW-1:0]  r_popped, n_popped;
    logic           r_pvalid, n_pvalid;
    logic           r_ovalid, n_ovalid;
    logic [imhq_pkg::M_DATA_W-1:0] r_odata, n_odata;

    logic           h_we, p_we;
    logic [AW-1:0]  h_waddr, h_raddr;
    logic [HW-1:0]  h_wdata, h_rdata;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [PW-1:0]  p_wdata, p_rdata;

    logic [KW-1:0]  h_key;
    logic [NW-1:0]  h_node;
    logic           p_pres;
    logic [AW-1:0]  p_slot;
    logic           in_acc, out_free, in_range, full;
    logic [CW-1:0]  cnt_m1;
    logic [AW-1:0]  parent;
    logic [CW:0]    dn_j0, dn_j1, cnt_x;
    logic           up_gt, cur_gt, dn_gt;

    imhq_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    imhq_ram #(.WIDTH(PW), .DEPTH(PD)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign h_key    = h_rdata[HW-1:NW];
    assign h_node   = h_rdata[NW-1:0];
    assign p_pres   = p_rdata[AW];
    assign p_slot   = p_rdata[AW-1:0];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign in_range = 32'(r_node) < 32'(MAX_NODES);
    assign full     = r_cnt == CW'(MAX_NODES);
    assign cnt_m1   = r_cnt - CW'(1);
    assign parent   = (r_i - AW'(1)) >> 1;
    assign dn_j0    = (CW+1)'({r_i, 1'b1});
    assign dn_j1    = dn_j0 + (CW+1)'(1);
    assign cnt_x    = (CW+1)'(r_cnt);
    assign up_gt    = $signed(r_mk) > $signed(h_key);
    assign cur_gt   = up_gt;
    assign dn_gt    = $signed(r_ck) > $signed(r_mk);

    assign s_axis_tready = r_state == imhq_pkg::S_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            imhq_pkg::S_INIT: begin
                if (r_init == PAW'(PD - 1)) n_state = imhq_pkg::S_IDLE;
            end
            imhq_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tdata[2:0] inside {imhq_pkg::ACT_INSERT, imhq_pkg::ACT_DELETE,
                                                  imhq_pkg::ACT_UPDATE, imhq_pkg::ACT_POP}) begin
                        n_state = imhq_pkg::S_DECIDE;
                    end else if (s_axis_tdata[2:0] == imhq_pkg::ACT_CLEAR) begin
                        n_state = imhq_pkg::S_CLR_RD;
                    end else begin
                        n_state = imhq_pkg::S_TOP_RD;
                    end
                end
            end
            imhq_pkg::S_DECIDE: begin
                n_state = imhq_pkg::S_TOP_RD;
                case (r_act)
                    imhq_pkg::ACT_INSERT: begin
                        if (!full && in_range && !p_pres) n_state = imhq_pkg::S_UP_RD;
                    end
                    imhq_pkg::ACT_DELETE: begin
                        if (in_range && p_pres && cnt_m1 != '0 && p_slot != AW'(cnt_m1))
                            n_state = imhq_pkg::S_LAST_RD;
                    end
                    imhq_pkg::ACT_UPDATE: begin
                        if (in_range && p_pres) n_state = imhq_pkg::S_CUR_RD;
                    end
                    imhq_pkg::ACT_POP: begin
                        if (r_cnt != '0 && cnt_m1 != '0) n_state = imhq_pkg::S_LAST_RD;
                    end
                    default: n_state = imhq_pkg::S_TOP_RD;
                endcase
            end
            imhq_pkg::S_LAST_RD:   n_state = imhq_pkg::S_LAST_WAIT;
            imhq_pkg::S_LAST_WAIT: begin
                n_state = (r_act == imhq_pkg::ACT_DELETE) ? imhq_pkg::S_CUR_RD
                                                          : imhq_pkg::S_DN_RD;
            end
            imhq_pkg::S_CUR_RD:   n_state = imhq_pkg::S_CUR_WAIT;
            imhq_pkg::S_CUR_WAIT: n_state = cur_gt ? imhq_pkg::S_UP_RD : imhq_pkg::S_DN_RD;
            imhq_pkg::S_UP_RD: begin
                n_state = (r_i == '0) ? imhq_pkg::S_TOP_RD : imhq_pkg::S_UP_WAIT;
            end
            imhq_pkg::S_UP_WAIT: n_state = up_gt ? imhq_pkg::S_UP_RD : imhq_pkg::S_TOP_RD;
            imhq_pkg::S_DN_RD: begin
                n_state = (dn_j0 < cnt_x) ? imhq_pkg::S_DN_WL : imhq_pkg::S_TOP_RD;
            end
            imhq_pkg::S_DN_WL: begin
                n_state = (dn_j1 < cnt_x) ? imhq_pkg::S_DN_WR : imhq_pkg::S_DN_MV;
            end
            imhq_pkg::S_DN_WR: n_state = imhq_pkg::S_DN_MV;
            imhq_pkg::S_DN_MV: n_state = dn_gt ? imhq_pkg::S_DN_RD : imhq_pkg::S_TOP_RD;
            imhq_pkg::S_CLR_RD: begin
                n_state = (r_ci < r_cnt) ? imhq_pkg::S_CLR_WR : imhq_pkg::S_TOP_RD;
            end
            imhq_pkg::S_CLR_WR:  n_state = imhq_pkg::S_CLR_RD;
            imhq_pkg::S_TOP_RD:  n_state = imhq_pkg::S_TOP_WAIT;
            imhq_pkg::S_TOP_WAIT: begin
                if (out_free) n_state = imhq_pkg::S_IDLE;
            end
            default: n_state = imhq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_act    = r_act;
        n_node   = r_node;
        n_key    = r_key;
        n_status = r_status;
        n_mk     = r_mk;
        n_mn     = r_mn;
        n_ck     = r_ck;
        n_cn     = r_cn;
        n_c      = r_c;
        n_i      = r_i;
        n_cnt    = r_cnt;
        n_ci     = r_ci;
        n_init   = r_init;
        n_popped = r_popped;
        n_pvalid = r_pvalid;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        h_we     = 1'b0;
        h_waddr  = r_i;
        h_wdata  = {r_mk, r_mn};
        h_raddr  = '0;
        p_we     = 1'b0;
        p_waddr  = PAW'(r_mn);
        p_wdata  = {1'b1, r_i};
        p_raddr  = PAW'(s_axis_tdata[12:3]);

        if (m_axis_tready) n_ovalid = 1'b0;

        case (r_state)
            imhq_pkg::S_INIT: begin
                p_we    = 1'b1;
                p_waddr = r_init;
                p_wdata = '0;
                n_init  = r_init + PAW'(1);
            end
            imhq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_act    = imhq_pkg::t_action'(s_axis_tdata[2:0]);
                    n_node   = s_axis_tdata[12:3];
                    n_key    = s_axis_tdata[13 +: KW];
                    n_status = imhq_pkg::STAT_OK;
                    n_popped = '0;
                    n_pvalid = 1'b0;
                    n_ci     = '0;
                end
            end
            imhq_pkg::S_DECIDE: begin
                case (r_act)
                    imhq_pkg::ACT_INSERT: begin
                        if (full) begin
                            n_status = imhq_pkg::STAT_FULL;
                        end else if (!in_range) begin
                            n_status = imhq_pkg::STAT_ABSENT;
                        end else if (p_pres) begin
                            n_status = imhq_pkg::STAT_PRESENT;
                        end else begin
                            n_i   = AW'(r_cnt);
                            n_cnt = r_cnt + CW'(1);
                            n_mk  = r_key;
                            n_mn  = r_node;
                        end
                    end
                    imhq_pkg::ACT_DELETE, imhq_pkg::ACT_UPDATE: begin
                        if (!in_range || !p_pres) begin
                            n_status = imhq_pkg::STAT_ABSENT;
                        end else begin
                            n_i  = p_slot;
                            n_mk = r_key;
                            n_mn = r_node;
                            if (r_act == imhq_pkg::ACT_DELETE) begin
                                p_we    = 1'b1;
                                p_waddr = PAW'(r_node);
                                p_wdata = '0;
                                n_cnt   = cnt_m1;
                            end
                        end
                    end
                    imhq_pkg::ACT_POP: begin
                        if (r_cnt != '0) begin
                            n_popped = h_node;
                            n_pvalid = 1'b1;
                            p_we     = 1'b1;
                            p_waddr  = PAW'(h_node);
                            p_wdata  = '0;
                            n_cnt    = cnt_m1;
                            n_i      = '0;
                        end
                    end
                    default: n_status = imhq_pkg::STAT_OK;
                endcase
            end
            imhq_pkg::S_LAST_RD: h_raddr = AW'(r_cnt);
            imhq_pkg::S_LAST_WAIT: begin
                n_mk = h_key;
                n_mn = h_node;
            end
            imhq_pkg::S_CUR_RD: h_raddr = r_i;
            imhq_pkg::S_UP_RD: begin
                if (r_i == '0) begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                end else begin
                    h_raddr = parent;
                end
            end
            imhq_pkg::S_UP_WAIT: begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (up_gt) begin
                    h_wdata = h_rdata;
                    p_waddr = PAW'(h_node);
                    n_i     = parent;
                end
            end
            imhq_pkg::S_DN_RD: begin
                if (dn_j0 < cnt_x) begin
                    h_raddr = AW'(dn_j0);
                end else begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                end
            end
            imhq_pkg::S_DN_WL: begin
                n_ck = h_key;
                n_cn = h_node;
                n_c  = AW'(dn_j0);
                if (dn_j1 < cnt_x) h_raddr = AW'(dn_j1);
            end
            imhq_pkg::S_DN_WR: begin
                if ($signed(h_key) > $signed(r_ck)) begin
                    n_ck = h_key;
                    n_cn = h_node;
                    n_c  = AW'(dn_j1);
                end
            end
            imhq_pkg::S_DN_MV: begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (dn_gt) begin
                    h_wdata = {r_ck, r_cn};
                    p_waddr = PAW'(r_cn);
                    n_i     = r_c;
                end
            end
            imhq_pkg::S_CLR_RD: begin
                if (r_ci < r_cnt) begin
                    h_raddr = AW'(r_ci);
                end else begin
                    n_cnt = '0;
                end
            end
            imhq_pkg::S_CLR_WR: begin
                p_we    = 1'b1;
                p_waddr = PAW'(h_node);
                p_wdata = '0;
                n_ci    = r_ci + CW'(1);
            end
            imhq_pkg::S_TOP_RD, imhq_pkg::S_TOP_WAIT: begin
                h_raddr = '0;
                if (r_state == imhq_pkg::S_TOP_WAIT && out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {6'd0, r_status, imhq_pkg::COUNT_OUT_W'(r_cnt),
                                (r_cnt != '0) ? 32'($signed(h_key)) : 32'd0,
                                (r_cnt != '0) ? h_node : NW'(0),
                                r_pvalid, r_popped};
                end
            end
            default: n_status = r_status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= imhq_pkg::S_INIT;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_init   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_init   <= n_init;
        end
        r_act    <= n_act;
        r_node   <= n_node;
        r_key    <= n_key;
        r_status <= n_status;
        r_mk     <= n_mk;
        r_mn     <= n_mn;
        r_ck     <= n_ck;
        r_cn     <= n_cn;
        r_c      <= n_c;
        r_i      <= n_i;
        r_ci     <= n_ci;
        r_popped <= n_popped;
        r_pvalid <= n_pvalid;
        r_odata  <= n_odata;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_NODES))
        else $error("entry count above capacity");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != imhq_pkg::S_IDLE)
        else $error("item accepted but sequencer stayed idle");

    a_pop_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid && r_state == imhq_pkg::S_TOP_WAIT |-> r_status == imhq_pkg::STAT_OK)
        else $error("pop removed a node with a non-ok status");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_we |-> (CW+1)'(h_waddr) < cnt_x)
        else $error("heap write at or above entry count");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for indexed_max_heap_queue: a directed and random stream of heap
// actions, checked result by result against an internal heap predictor. Uses imhq_pkg.
module tb;

    localparam int NODES = 1024;
    localparam int WATCH_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [imhq_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [imhq_pkg::M_DATA_W-1:0] m_axis_tdata;

    indexed_max_heap_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] count;
        logic [31:0] top_key;
        logic [9:0]  top_node;
        logic        popped_valid;
        logic [9:0]  popped_node;
    } t_heap_result;

    logic [imhq_pkg::S_DATA_W-1:0] pending_items[$];
    t_heap_result expected_results[$];

    logic signed [31:0] heap_key[NODES];
    logic [9:0] heap_node[NODES];
    int node_slot[NODES];
    bit node_in_heap[NODES];
    int heap_count;
    int errors;
    int watch;
    bit hold_for_drain;
    bit quiet_end;
    int send_gap;
    int recv_gap;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void place(int i, logic signed [31:0] k, logic [9:0] n);
        heap_key[i] = k;
        heap_node[i] = n;
        node_slot[n] = i;
    endfunction

    function automatic void bubble_up(int i, logic signed [31:0] k, logic [9:0] n);
        int p;
        while (i > 0) begin
            p = (i - 1) >> 1;
            if (k > heap_key[p]) begin
                place(i, heap_key[p], heap_node[p]);
                i = p;
            end else begin
                break;
            end
        end
        place(i, k, n);
    endfunction

    function automatic void bubble_down(int i, logic signed [31:0] k, logic [9:0] n);
        int j;
        int c;
        while ((j = 2 * i + 1) < heap_count) begin
            c = j;
            if (j + 1 < heap_count && heap_key[j + 1] > heap_key[j]) c = j + 1;
            if (heap_key[c] > k) begin
                place(i, heap_key[c], heap_node[c]);
                i = c;
            end else begin
                break;
            end
        end
        place(i, k, n);
    endfunction

    function automatic void resettle(int i, logic signed [31:0] k, logic [9:0] n);
        if (k > heap_key[i]) bubble_up(i, k, n);
        else bubble_down(i, k, n);
    endfunction

    function automatic t_heap_result apply_action(logic [imhq_pkg::S_DATA_W-1:0] d);
        t_heap_result r;
        logic [2:0] act;
        logic [9:0] n;
        logic signed [31:0] k;
        int i;
        act = d[2:0];
        n = d[12:3];
        k = d[44:13];
        r = '0;
        r.status = imhq_pkg::STAT_OK;
        case (act)
            imhq_pkg::ACT_INSERT: begin
                if (heap_count >= NODES) r.status = imhq_pkg::STAT_FULL;
                else if (node_in_heap[n]) r.status = imhq_pkg::STAT_PRESENT;
                else begin
                    node_in_heap[n] = 1'b1;
                    heap_count++;
                    bubble_up(heap_count - 1, k, n);
                end
            end
            imhq_pkg::ACT_DELETE: begin
                if (!node_in_heap[n]) r.status = imhq_pkg::STAT_ABSENT;
                else begin
                    i = node_slot[n];
                    node_in_heap[n] = 1'b0;
                    heap_count--;
                    if (heap_count > 0 && i != heap_count)
                        resettle(i, heap_key[heap_count], heap_node[heap_count]);
                end
            end
            imhq_pkg::ACT_UPDATE: begin
                if (!node_in_heap[n]) r.status = imhq_pkg::STAT_ABSENT;
                else resettle(node_slot[n], k, n);
            end
            imhq_pkg::ACT_POP: begin
                if (heap_count > 0) begin
                    r.popped_node = heap_node[0];
                    r.popped_valid = 1'b1;
                    node_in_heap[heap_node[0]] = 1'b0;
                    heap_count--;
                    if (heap_count > 0)
                        bubble_down(0, heap_key[heap_count], heap_node[heap_count]);
                end
            end
            imhq_pkg::ACT_CLEAR: begin
                for (i = 0; i < heap_count; i++) node_in_heap[heap_node[i]] = 1'b0;
                heap_count = 0;
            end
            default: ;
        endcase
        r.count = heap_count[10:0];
        if (heap_count > 0) begin
            r.top_node = heap_node[0];
            r.top_key = heap_key[0];
        end
        return r;
    endfunction

    function automatic logic [imhq_pkg::S_DATA_W-1:0] make_item(logic [2:0] act,
                                                                logic [9:0] n,
                                                                logic [31:0] k);
        logic [imhq_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[2:0] = act;
        d[12:3] = n;
        d[44:13] = k;
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: a burst of idle cycles may follow any accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_action(s_axis_tdata));
                void'(pending_items.pop_front());
                if (!quiet_end && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
            end
            if (send_gap > 0 && !(s_axis_tvalid && !s_axis_tready)) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (pending_items.size() > 0 && !(hold_for_drain && expected_results.size() > 0)
                        && !(hold_for_drain && s_axis_tvalid && s_axis_tready)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_items[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_heap_result got;
        t_heap_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[65:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got.top_node), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.popped_node !== want.popped_node)
                        report_mismatch("popped_node", 32'(got.popped_node),
                                        32'(want.popped_node));
                    if (got.popped_valid !== want.popped_valid)
                        report_mismatch("popped_valid", 32'(got.popped_valid),
                                        32'(want.popped_valid));
                    if (got.top_node !== want.top_node)
                        report_mismatch("top_node", 32'(got.top_node), 32'(want.top_node));
                    if (got.top_key !== want.top_key)
                        report_mismatch("top_key", got.top_key, want.top_key);
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_end && $urandom_range(0, 15) == 0) begin
                recv_gap = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) watch = 0;
            else watch++;
            if (watch >= WATCH_LIMIT) begin
                $display("indexed_max_heap_queue verification failed");
                $finish;
            end
        end
    end

    task automatic add_random(int cnt, int id_span);
        int a;
        logic [31:0] k;
        logic [9:0] id;
        logic [2:0] act;
        for (int j = 0; j < cnt; j++) begin
            a = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) - 8 : $urandom;
            id = 10'($urandom_range(0, id_span));
            if (a < 45) begin
                act = imhq_pkg::ACT_INSERT;
            end else if (a < 60) begin
                act = imhq_pkg::ACT_DELETE;
            end else if (a < 75) begin
                act = imhq_pkg::ACT_UPDATE;
            end else if (a < 95) begin
                act = imhq_pkg::ACT_POP;
                id = 10'($urandom);
                k = $urandom;
            end else if (a < 97) begin
                act = imhq_pkg::ACT_CLEAR;
                id = 10'($urandom);
                k = $urandom;
            end else begin
                act = 3'($urandom_range(5, 7));
                id = 10'($urandom);
                k = $urandom;
            end
            pending_items.push_back(make_item(act, id, k));
        end
    endtask

    initial begin
        int settle;
        errors = 0;
        watch = 0;
        heap_count = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_for_drain = 0;
        quiet_end = 0;
        for (int i = 0; i < NODES; i++) node_in_heap[i] = 0;

        pending_items.push_back(make_item(imhq_pkg::ACT_POP, 10'd0, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_DELETE, 10'd5, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_UPDATE, 10'd1023, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd0, 32'h8000_0000));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd1023, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd1023, 32'd1));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd7, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd8, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd9, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(imhq_pkg::ACT_UPDATE, 10'd0, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(imhq_pkg::ACT_UPDATE, 10'd1023, 32'h8000_0000));
        pending_items.push_back(make_item(imhq_pkg::ACT_DELETE, 10'd7, 32'd0));
        pending_items.push_back(make_item(3'd5, 10'h3FF, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(3'd7, 10'd0, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_POP, 10'd0, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_CLEAR, 10'd0, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_POP, 10'd0, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_INSERT, 10'd3, 32'd0));
        pending_items.push_back(make_item(imhq_pkg::ACT_CLEAR, 10'd0, 32'd0));
        add_random(281, 63);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        hold_for_drain = 1;
        add_random(100, 1023);
        wait (expected_results.size() == 0);
        hold_for_drain = 0;
        wait (pending_items.size() == 0);
        quiet_end = 1;
        add_random(100, 31);
        wait (pending_items.size() == 0);
        settle = 0;
        while (expected_results.size() > 0 && settle < WATCH_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("indexed_max_heap_queue verification clean");
        else
            $display("indexed_max_heap_queue verification failed");
        $finish;
    end
endmodule
